// ===== rtl/core/lcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpd_pkg
// Shared types and constants of the level crossing pair detector.
// ----------------------------------------------------------------------------
`default_nettype none

package lcpd_pkg;

  localparam longint LCPD_MAX_RECORD_LEN = 64'd1048576;
  localparam int     LCPD_SAMPLE_BITS    = 16;

  localparam int IDX_W       = 20;
  localparam int TH_W        = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             positive_level;
    logic             first_entering;
    logic             last_of_item;
  } pair_t;

  typedef struct packed {
    logic [1:0] cnt;
    pair_t      p0;
    pair_t      p1;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/level_crossing_pair_detector.sv =====
// ----------------------------------------------------------------------------
// level_crossing_pair_detector
// Finds entering/leaving level crossing points in a sample record and
// reports same-polarity pairs of opposite direction.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  cfg      in   cfg_wr_en          cfg_wr_data (threshold level)
//  in       in   in_valid/in_ready  in_sample, in_record_end
//  out      out  out_valid/out_ready first/second index, polarity, entering, last
//
//  an input beat is taken in one cycle while the queue has two free slots
//  a sample yields zero, one or two pairs; the output stage drains one pair
//  per cycle while out_ready is high
//  synchronous reset clears all history and the queue, no clearing pass
//  output stalls are absorbed by a four-entry queue, then in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module level_crossing_pair_detector
  import lcpd_pkg::*;
#(
  parameter longint MAX_RECORD_LEN = LCPD_MAX_RECORD_LEN,
  parameter int     SAMPLE_BITS    = LCPD_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [TH_W-1:0]        cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_record_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       out_first_index,
  output logic [IDX_W-1:0]       out_second_index,
  output logic                   out_positive_level,
  output logic                   out_first_entering,
  output logic                   out_last_of_item
);

  push_t push;
  logic  q_space, q_valid, q_pop;
  pair_t q_head, out_pair;

  lcpd_front #(
    .MAX_RECORD_LEN(MAX_RECORD_LEN),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_record_end(in_record_end),
    .q_space      (q_space),
    .push         (push)
  );

  lcpd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_space(q_space),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  lcpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pair (out_pair)
  );

  assign out_first_index    = out_pair.first_index;
  assign out_second_index   = out_pair.second_index;
  assign out_positive_level = out_pair.positive_level;
  assign out_first_entering = out_pair.first_entering;
  assign out_last_of_item   = out_pair.last_of_item;

endmodule

`default_nettype wire

// ===== rtl/core/lcpd_front.sv =====
// ----------------------------------------------------------------------------
// lcpd_front
// Sample history, crossing classification and pending point tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_front
  import lcpd_pkg::*;
#(
  parameter longint MAX_RECORD_LEN = LCPD_MAX_RECORD_LEN,
  parameter int     SAMPLE_BITS    = LCPD_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [TH_W-1:0]        cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_record_end,
  input  logic                   q_space,
  output push_t                  push
);

  localparam int CNT_W = $clog2(MAX_RECORD_LEN);
  localparam int EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int CMP_W = (SAMPLE_BITS > TH_W) ? SAMPLE_BITS : TH_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORD_LEN - 64'd1);

  logic [TH_W-1:0]        threshold_r;
  logic [SAMPLE_BITS-1:0] older_r, middle_r;
  logic [CNT_W-1:0]       count_r;
  logic                   pend_valid_r, pend_pos_r, pend_ent_r;
  logic [IDX_W-1:0]       pend_idx_r;

  logic                   accept;
  logic [CMP_W-1:0]       lvl;
  logic                   mid_hit, pos, enter, leave, pair_a, pair_b;
  logic [EXT_W-1:0]       cnt_ext;
  logic [IDX_W-1:0]       idx_a, idx_b;
  pair_t                  a, b;

  function automatic logic [CMP_W-1:0] mag(input logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] m;
    m = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
    return CMP_W'(m);
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = q_space;
  assign lvl      = CMP_W'(threshold_r);
  assign cnt_ext  = EXT_W'(count_r);
  assign idx_b    = IDX_W'(cnt_ext - EXT_W'(1));
  assign idx_a    = IDX_W'(cnt_ext - EXT_W'(2));

  always_comb begin
    mid_hit = (count_r >= CNT_W'(2)) && (mag(middle_r) >= lvl);
    pos     = !middle_r[SAMPLE_BITS-1] && (middle_r != '0);
    enter   = mid_hit && ((mag(older_r) < lvl) ||
                          (older_r[SAMPLE_BITS-1] != middle_r[SAMPLE_BITS-1]));
    leave   = mid_hit && ((mag(in_sample) < lvl) ||
                          (in_sample[SAMPLE_BITS-1] != middle_r[SAMPLE_BITS-1]));
    pair_a  = enter && pend_valid_r && (pend_pos_r == pos) && !pend_ent_r;
    // a leaving point right after an entering point of the same sample always pairs
    pair_b  = leave && (enter || (pend_valid_r && (pend_pos_r == pos) && pend_ent_r));

    a.first_index    = pend_idx_r;
    a.second_index   = idx_a;
    a.positive_level = pos;
    a.first_entering = pend_ent_r;
    a.last_of_item   = !pair_b;

    b.first_index    = enter ? idx_a : pend_idx_r;
    b.second_index   = idx_b;
    b.positive_level = pos;
    b.first_entering = enter ? 1'b1 : pend_ent_r;
    b.last_of_item   = 1'b1;

    push.p0  = pair_a ? a : b;
    push.p1  = b;
    push.cnt = accept ? (2'(pair_a) + 2'(pair_b)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= '0;
      older_r      <= '0;
      middle_r     <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      pend_idx_r   <= '0;
      pend_pos_r   <= 1'b0;
      pend_ent_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_record_end) begin
          older_r      <= '0;
          middle_r     <= '0;
          count_r      <= '0;
          pend_valid_r <= 1'b0;
          pend_idx_r   <= '0;
          pend_pos_r   <= 1'b0;
          pend_ent_r   <= 1'b0;
        end else begin
          older_r  <= middle_r;
          middle_r <= in_sample;
          if (count_r != CNT_MAX) begin
            count_r <= count_r + CNT_W'(1);
          end
          if (leave) begin
            pend_valid_r <= 1'b1;
            pend_idx_r   <= idx_b;
            pend_pos_r   <= pos;
            pend_ent_r   <= 1'b0;
          end else if (enter) begin
            pend_valid_r <= 1'b1;
            pend_idx_r   <= idx_a;
            pend_pos_r   <= pos;
            pend_ent_r   <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcpd_queue.sv =====
// ----------------------------------------------------------------------------
// lcpd_queue
// Short pair queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_queue
  import lcpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  q_space,
  output logic  q_valid,
  output pair_t q_head,
  input  logic  q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  pair_t            entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]  cnt_r;

  assign q_space = cnt_r <= QC_W'(QUEUE_DEPTH - 2);
  assign q_valid = cnt_r != '0;
  assign q_head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries_r[wr_ptr_r] <= push.p0;
    end
    if (push.cnt == 2'd2) begin
      entries_r[wr_ptr_r + PTR_W'(1)] <= push.p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(q_pop);
      cnt_r    <= cnt_r + QC_W'(push.cnt) - QC_W'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcpd_back.sv =====
// ----------------------------------------------------------------------------
// lcpd_back
// Output stage, presents one pair per beat from the queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_back
  import lcpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_valid,
  input  pair_t q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output pair_t out_pair
);

  logic  out_valid_r;
  pair_t out_pair_r;
  logic  load;

  assign load      = !out_valid_r || out_ready;
  assign q_pop     = load && q_valid;
  assign out_valid = out_valid_r;
  assign out_pair  = out_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_pair_r <= q_head;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcpd_checker.sv =====
// ----------------------------------------------------------------------------
// lcpd_checker
// Port-level checks of the level crossing pair detector.
// ----------------------------------------------------------------------------
`default_nettype none

module lcpd_checker
  import lcpd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_first_index,
  input logic [IDX_W-1:0] out_second_index,
  input logic             out_positive_level,
  input logic             out_first_entering,
  input logic             out_last_of_item
);

  logic out_hs;
  assign out_hs = out_valid && out_ready;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_index) &&
      $stable(out_second_index) && $stable(out_positive_level) &&
      $stable(out_first_entering) && $stable(out_last_of_item))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // second pair of a sample is already queued when the first one leaves
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs && !out_last_of_item |=> out_valid)
    else $error("no second pair after a non-final beat");

  // two pairs of one sample chain through the entering point
  a_pair_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs && !out_last_of_item |=> out_first_entering && out_last_of_item &&
      (out_positive_level == $past(out_positive_level)) &&
      (out_first_index == $past(out_second_index)) && !$past(out_first_entering))
    else $error("second pair of a sample does not chain to the first");

endmodule

bind level_crossing_pair_detector lcpd_checker u_lcpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_first_index   (out_first_index),
  .out_second_index  (out_second_index),
  .out_positive_level(out_positive_level),
  .out_first_entering(out_first_entering),
  .out_last_of_item  (out_last_of_item)
);

`default_nettype wire

// ===== dv/level_crossing_pair_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_crossing_pair_detector_test
// Drives sample records into the detector and predicts the level crossing
// pairs each sample beat should produce: entering and leaving points,
// polarity, record end, zero level, full-scale samples and levels. Results
// are checked in order against the prediction under random idling on both
// channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------

module level_crossing_pair_detector_test;
  import lcpd_pkg::*;

  typedef logic signed [LCPD_SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SMAX = 16'sh7fff;
  localparam sample_t SMIN = 16'sh8000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [TH_W-1:0]              cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [LCPD_SAMPLE_BITS-1:0]  in_sample = '0;
  logic                         in_record_end = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [IDX_W-1:0]             out_first_index;
  logic [IDX_W-1:0]             out_second_index;
  logic                         out_positive_level;
  logic                         out_first_entering;
  logic                         out_last_of_item;

  level_crossing_pair_detector dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_record_end      (in_record_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_first_index    (out_first_index),
    .out_second_index   (out_second_index),
    .out_positive_level (out_positive_level),
    .out_first_entering (out_first_entering),
    .out_last_of_item   (out_last_of_item)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [TH_W-1:0]  level_reg = '0;
  sample_t          lag2_sample = '0;
  sample_t          lag1_sample = '0;
  int unsigned      record_pos = 0;
  bit               open_valid = 1'b0;
  logic [IDX_W-1:0] open_index = '0;
  bit               open_positive = 1'b0;
  bit               open_entering = 1'b0;
  int               item_pairs;

  pair_t   expected_pairs[$];
  sample_t record_buf[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int draw_kind = 0;
  int samples_sent = 0;
  int records_sent = 0;
  int pairs_checked = 0;
  int fail_count = 0;

  function automatic int mag(sample_t v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  function automatic bit crosses(sample_t nb, sample_t cur);
    return (mag(nb) < int'(level_reg)) || ((nb >= 0) != (cur >= 0));
  endfunction

  function automatic void place_point(logic [IDX_W-1:0] idx, bit pos, bit entering);
    pair_t p;
    if (open_valid && open_positive == pos && open_entering != entering) begin
      p = {open_index, idx, pos, open_entering, 1'b0};
      expected_pairs = {expected_pairs, p};
      item_pairs++;
    end
    open_valid = 1'b1;
    open_index = idx;
    open_positive = pos;
    open_entering = entering;
  endfunction

  // the middle sample is judged once its right neighbour arrives
  function automatic void predict_pairs(sample_t s, bit last);
    sample_t          mid;
    logic [IDX_W-1:0] mid_idx;
    bit               pos;
    pair_t            tail;
    item_pairs = 0;
    if (record_pos >= 2) begin
      mid = lag1_sample;
      mid_idx = IDX_W'(record_pos - 1);
      if (mag(mid) >= int'(level_reg)) begin
        pos = (mid > 0);
        if (crosses(lag2_sample, mid)) place_point(mid_idx - 1'b1, pos, 1'b1);
        if (crosses(s, mid)) place_point(mid_idx, pos, 1'b0);
      end
    end
    if (item_pairs > 0) begin
      tail = expected_pairs[expected_pairs.size() - 1];
      tail.last_of_item = 1'b1;
      expected_pairs[expected_pairs.size() - 1] = tail;
    end
    if (last) begin
      lag2_sample = '0;
      lag1_sample = '0;
      record_pos = 0;
      open_valid = 1'b0;
      open_index = '0;
      open_positive = 1'b0;
      open_entering = 1'b0;
    end else begin
      lag2_sample = lag1_sample;
      lag1_sample = s;
      if (longint'(record_pos) < LCPD_MAX_RECORD_LEN - 1) record_pos++;
    end
  endfunction

  // runs of below-level, positive, negative or raw samples
  function automatic sample_t draw_sample();
    int lo;
    if ($urandom_range(1)) draw_kind = $urandom_range(3);
    lo = (level_reg == 0) ? 1 : int'(level_reg);
    case (draw_kind)
      0: begin
        if (level_reg == 0) return sample_t'(0);
        return sample_t'(int'($urandom_range(2 * lo - 2)) - (lo - 1));
      end
      1: begin
        if (lo > 32767) return sample_t'($urandom_range(32767, 1));
        return sample_t'($urandom_range(32767, lo));
      end
      2: return sample_t'(-int'($urandom_range(32768, lo)));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(sample_t s, bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_record_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_pairs(s, last);
    samples_sent++;
    if (last) records_sent++;
  endtask

  task automatic send_record();
    foreach (record_buf[k]) send_sample(record_buf[k], k == record_buf.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && expected_pairs.size() > 0; n++) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_level(logic [TH_W-1:0] lvl);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lvl;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    level_reg = lvl;
  endtask

  task automatic test_short_records();
    set_level(16'd10);
    record_buf = '{16'sd500};
    send_record();
    record_buf = '{16'sd500, -16'sd500};
    send_record();
    drain();
  endtask

  // one beat closes a leaving point and opens a new pulse: two pairs
  task automatic test_paired_pulse();
    set_level(16'd100);
    record_buf = '{16'sd0, 16'sd500, 16'sd500, 16'sd0, 16'sd500, 16'sd0};
    send_record();
    drain();
  endtask

  task automatic test_zero_level();
    set_level(16'd0);
    record_buf = '{16'sd0, 16'sd0, 16'sd5, 16'sd0, -16'sd3, 16'sd0};
    send_record();
    drain();
  endtask

  task automatic test_extreme_samples();
    set_level(16'd100);
    record_buf = '{16'sd0, SMAX, SMIN, SMIN, 16'sd7};
    send_record();
    drain();
  endtask

  task automatic test_full_scale_level();
    set_level(16'h8000);
    record_buf = '{16'sd0, SMIN, SMAX};
    send_record();
    drain();
  endtask

  // output held off while alternating signs keep the pair queue filling
  task automatic test_back_pressure();
    int m;
    set_level(16'd0);
    send_idle_pct = 0;
    stall_pct = 0;
    record_buf.delete();
    for (int k = 0; k < 40; k++) begin
      m = $urandom_range(32767, 1);
      record_buf = {record_buf, (k % 2) ? sample_t'(-m) : sample_t'(m)};
    end
    @(posedge clk);
    hold_left = 300;
    send_record();
    drain();
  endtask

  task automatic test_random_records(int n_samples, logic [TH_W-1:0] lvl, int idle, int stall);
    int pick;
    int len;
    set_level(lvl);
    send_idle_pct = idle;
    stall_pct = stall;
    while (n_samples > 0) begin
      pick = $urandom_range(99);
      if (pick < 10) len = $urandom_range(2, 1);
      else if (pick < 85) len = $urandom_range(24, 3);
      else len = $urandom_range(120, 25);
      record_buf.delete();
      repeat (len) record_buf = {record_buf, draw_sample()};
      send_record();
      n_samples -= len;
    end
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : pair_check
    pair_t got;
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_first_index, out_second_index, out_positive_level, out_first_entering,
             out_last_of_item};
      if (expected_pairs.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected pair: first=%0d second=%0d pos=%0b ent=%0b last=%0b",
                   got.first_index, got.second_index, got.positive_level,
                   got.first_entering, got.last_of_item);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.first_index !== want.first_index || got.second_index !== want.second_index ||
            got.positive_level !== want.positive_level ||
            got.first_entering !== want.first_entering ||
            got.last_of_item !== want.last_of_item) begin
          if (fail_count < 10) begin
            $display("pair %0d: expected first=%0d second=%0d pos=%0b ent=%0b last=%0b",
                     pairs_checked, want.first_index, want.second_index,
                     want.positive_level, want.first_entering, want.last_of_item);
            $display("  got first=%0d second=%0d pos=%0b ent=%0b last=%0b",
                     got.first_index, got.second_index, got.positive_level,
                     got.first_entering, got.last_of_item);
          end
          fail_count++;
        end
        pairs_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_records();
    test_paired_pulse();
    test_zero_level();
    test_extreme_samples();
    test_full_scale_level();
    test_back_pressure();
    test_random_records(110, TH_W'($urandom_range(2000, 1)), 0, 0);
    test_random_records(110, 16'd0, 72, 0);
    test_random_records(110, TH_W'($urandom_range(32767, 1)), 0, 72);
    test_random_records(110, TH_W'($urandom_range(500, 1)), 29, 29);
    test_random_records(40, 16'h8000, 29, 29);
    drain();

    if (expected_pairs.size() != 0) begin
      $display("%0d expected pairs never arrived", expected_pairs.size());
      fail_count++;
    end
    $display("%0d sample beats in %0d records, %0d pairs compared, %0d failures",
             samples_sent, records_sent, pairs_checked, fail_count);
    $display("levels 0 to 32768, idle and stall up to 72 percent, one 300-cycle output hold-off");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lcpd_pkg.sv
rtl/core/lcpd_front.sv
rtl/core/lcpd_queue.sv
rtl/core/lcpd_back.sv
rtl/core/level_crossing_pair_detector.sv
rtl/core/lcpd_checker.sv
dv/level_crossing_pair_detector_test.sv
